### rtl/bw_ratio_cwnd_update_macros.svh
// Assertion macros shared by the block.
`ifndef BW_RATIO_CWND_UPDATE_MACROS_SVH
`define BW_RATIO_CWND_UPDATE_MACROS_SVH

// Condition must hold in the same cycle.
`define BWR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition must hold in the following cycle.
`define BWR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bwr_pkg.sv
package bwr_pkg;

  localparam int unsigned SEG_W = 16;
  localparam int unsigned BW_W = 48;
  localparam int unsigned WIN_W = 32;
  localparam int unsigned ACK_W = 16;
  localparam int unsigned SUM_W = BW_W + 1;

  localparam logic [SEG_W-1:0] SEG_RESET = 16'd536;

  typedef enum logic [1:0] {
    REGIME_NONE   = 2'd0,
    REGIME_FAST   = 2'd1,
    REGIME_NORMAL = 2'd2,
    REGIME_DECAY  = 2'd3
  } regime_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### rtl/bwr_divider.sv
module bwr_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [bwr_pkg::WIN_W-1:0]       dividend,
  input  logic [bwr_pkg::WIN_W-1:0]       divisor,
  output logic [bwr_pkg::WIN_W-1:0]       quotient,
  output bwr_pkg::unit_stat_t             stat
);

  localparam int unsigned CNT_W = $clog2(bwr_pkg::WIN_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(bwr_pkg::WIN_W - 1);

  logic [bwr_pkg::WIN_W-1:0] rem;
  logic [bwr_pkg::WIN_W-1:0] dvd;
  logic [bwr_pkg::WIN_W-1:0] dsr;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;

  logic [bwr_pkg::WIN_W:0]   trial;
  logic                      fits;
  logic [bwr_pkg::WIN_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dvd[bwr_pkg::WIN_W-1]};
    fits = trial >= {1'b0, dsr};
    if (fits) begin
      rem_next = bwr_pkg::WIN_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[bwr_pkg::WIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt <= '0;
        rem <= '0;
        dvd <= dividend;
        dsr <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[bwr_pkg::WIN_W-2:0], fits};
        cnt <= cnt + 1'b1;
        done <= (cnt == LAST);
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quotient = dvd;
  assign stat = '{busy: busy, done: done};

endmodule

### rtl/bwr_muldiv.sv
module bwr_muldiv (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [bwr_pkg::WIN_W-1:0]       mult,
  input  logic [bwr_pkg::SUM_W-1:0]       addend,
  input  logic [bwr_pkg::SUM_W-1:0]       divisor,
  output logic [bwr_pkg::WIN_W-1:0]       quotient,
  output bwr_pkg::unit_stat_t             stat
);

  localparam int unsigned CNT_W = $clog2(bwr_pkg::WIN_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(bwr_pkg::WIN_W - 1);
  localparam int unsigned SW = bwr_pkg::SUM_W;

  logic [SW-1:0]             rem;
  logic [SW-1:0]             add_r;
  logic [SW-1:0]             dsr;
  logic [bwr_pkg::WIN_W-1:0] msh;
  logic [bwr_pkg::WIN_W-1:0] quo;
  logic [CNT_W-1:0]          cnt;
  logic                      phase;
  logic                      busy;
  logic                      done;

  logic [SW:0]   t_dbl;
  logic [SW:0]   t_add;
  logic          ge_dbl;
  logic          ge_add;

  // For each multiplier bit, the partial remainder is first doubled, then the addend is added.
  always_comb begin
    t_dbl = {rem, 1'b0};
    ge_dbl = t_dbl >= {1'b0, dsr};
    t_add = {1'b0, rem} + (msh[bwr_pkg::WIN_W-1] ? {1'b0, add_r} : '0);
    ge_add = t_add >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
      phase <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt <= '0;
        phase <= 1'b0;
        rem <= '0;
        quo <= '0;
        msh <= mult;
        add_r <= addend;
        dsr <= divisor;
      end else if (busy) begin
        phase <= ~phase;
        if (!phase) begin
          done <= 1'b0;
          if (ge_dbl) begin
            rem <= SW'(t_dbl - {1'b0, dsr});
          end else begin
            rem <= t_dbl[SW-1:0];
          end
          quo <= {quo[bwr_pkg::WIN_W-2:0], ge_dbl};
        end else begin
          if (ge_add) begin
            rem <= SW'(t_add - {1'b0, dsr});
            quo <= quo + 1'b1;
          end else begin
            rem <= t_add[SW-1:0];
          end
          msh <= {msh[bwr_pkg::WIN_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          done <= (cnt == LAST);
          if (cnt == LAST) begin
            busy <= 1'b0;
          end
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quotient = quo;
  assign stat = '{busy: busy, done: done};

endmodule

### rtl/bw_ratio_cwnd_update.sv
// An ACK with no acked segments passes straight from classify to the output; a decay
// update waits on the serial multiply-divide (64 steps), and a growth update on the
// serial divider (two 32-step passes, or one pass when segment_size is zero).
// The next ACK is taken in the cycle after a result is registered, so one ACK is
// processed at a time, and a stalled output holds off the next ACK.
// Reset (synchronous, active high) sets segment_size to 536 and clears state.
module bw_ratio_cwnd_update (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // acked_segments, current_bandwidth, window_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // window_out
  output logic [7:0]  m_tuser,   // regime, zero padding
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  `include "bw_ratio_cwnd_update_macros.svh"

  localparam int unsigned WW = bwr_pkg::WIN_W;
  localparam int unsigned BW = bwr_pkg::BW_W;
  localparam int unsigned SW = bwr_pkg::SUM_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_WAIT_Q,
    ST_WAIT_ADD,
    ST_WAIT_MD,
    ST_DONE
  } state_t;

  state_t                      state;
  logic [bwr_pkg::SEG_W-1:0]   seg;
  logic [BW-1:0]               prev;
  logic [bwr_pkg::ACK_W-1:0]   acked;
  logic [BW-1:0]               cur;
  logic [WW-1:0]               win;
  logic                        fast;
  logic [WW-1:0]               result;
  bwr_pkg::regime_t            regime;

  logic                        div_start;
  logic [WW-1:0]               div_dividend;
  logic [WW-1:0]               div_divisor;
  logic [WW-1:0]               div_quo;
  bwr_pkg::unit_stat_t         div_stat;

  logic                        md_start;
  logic [SW-1:0]               md_addend;
  logic [SW-1:0]               md_divisor;
  logic [WW-1:0]               md_quo;
  bwr_pkg::unit_stat_t         md_stat;

  logic                        is_decay;
  logic                        is_fast;
  logic [SW:0]                 prev_x3;
  logic [SW:0]                 cur_x2;
  logic [WW:0]                 grow_sum;
  logic [WW-1:0]               grow_add;
  logic [WW-1:0]               q_cnt;
  logic                        out_free;

  bwr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  bwr_muldiv u_md (
    .clk      (clk),
    .rst      (rst),
    .start    (md_start),
    .mult     (win),
    .addend   (md_addend),
    .divisor  (md_divisor),
    .quotient (md_quo),
    .stat     (md_stat)
  );

  always_comb begin
    prev_x3 = {2'b00, prev} + {1'b0, prev, 1'b0};
    cur_x2 = {1'b0, cur, 1'b0};
    is_decay = (prev != '0) && (cur < prev);
    is_fast = (prev != '0) && (cur_x2 >= prev_x3);
    q_cnt = (div_quo == '0) ? WW'(1) : div_quo;
    grow_add = (div_quo == '0) ? WW'(1) : div_quo;
    grow_sum = {1'b0, win} + {1'b0, grow_add};
    out_free = !m_tvalid || m_tready;
  end

  assign s_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seg <= bwr_pkg::SEG_RESET;
      prev <= '0;
      m_tvalid <= 1'b0;
      div_start <= 1'b0;
      md_start <= 1'b0;
    end else begin
      div_start <= ((state == ST_CLASSIFY) && (acked != '0) && !is_decay) ||
                   ((state == ST_WAIT_Q) && div_stat.done);
      md_start <= (state == ST_CLASSIFY) && (acked != '0) && is_decay;
      if (cfg_valid && cfg_ready) begin
        seg <= cfg_data;
      end
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            acked <= s_tdata[15:0];
            cur <= s_tdata[63:16];
            win <= s_tdata[95:64];
            state <= ST_CLASSIFY;
          end
        end
        ST_CLASSIFY: begin
          if (acked == '0) begin
            result <= win;
            regime <= bwr_pkg::REGIME_NONE;
            state <= ST_DONE;
          end else begin
            prev <= cur;
            fast <= is_fast;
            md_addend <= {1'b0, prev} + {1'b0, cur};
            md_divisor <= {prev, 1'b0};
            if (is_decay) begin
              state <= ST_WAIT_MD;
            end else if (seg == '0) begin
              div_dividend <= '0;
              div_divisor <= WW'(1);
              state <= ST_WAIT_ADD;
            end else begin
              div_dividend <= win;
              div_divisor <= WW'(seg);
              state <= ST_WAIT_Q;
            end
          end
        end
        ST_WAIT_Q: begin
          if (div_stat.done) begin
            div_dividend <= fast ? WW'({seg, 1'b0}) : WW'(seg);
            div_divisor <= q_cnt;
            state <= ST_WAIT_ADD;
          end
        end
        ST_WAIT_ADD: begin
          if (div_stat.done) begin
            result <= grow_sum[WW] ? '1 : grow_sum[WW-1:0];
            regime <= fast ? bwr_pkg::REGIME_FAST : bwr_pkg::REGIME_NORMAL;
            state <= ST_DONE;
          end
        end
        ST_WAIT_MD: begin
          if (md_stat.done) begin
            result <= (md_quo < WW'(seg)) ? WW'(seg) : md_quo;
            regime <= bwr_pkg::REGIME_DECAY;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tdata <= result;
            m_tuser <= {6'b000000, regime};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BWR_ASSERT_SAME(a_idle_units_quiet, clk, rst, state == ST_IDLE, !div_stat.busy && !md_stat.busy, "unit busy while idle")
  `BWR_ASSERT_SAME(a_div_done_expected, clk, rst, div_stat.done, state == ST_WAIT_Q || state == ST_WAIT_ADD, "unexpected divider completion")
  `BWR_ASSERT_SAME(a_md_done_expected, clk, rst, md_stat.done, state == ST_WAIT_MD, "unexpected multiply-divide completion")
  `BWR_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, s_tvalid && s_tready, state == ST_CLASSIFY, "input transfer not taken up")

endmodule
